// ----- rtl/qfc_pkg.sv -----
package qfc_pkg;

   localparam int FRAC_BITS_DEFAULT = 8;

   typedef enum logic [1:0] {
      FUNC_INT_TO_FIX   = 2'd0,
      FUNC_FLT_TO_FIX   = 2'd1,
      FUNC_FIX_TO_FLT   = 2'd2,
      FUNC_FIX_TO_INT   = 2'd3
   } func_type;

   typedef struct packed {
      logic [31:0] fixed_value;
      logic [31:0] float_bits;
      logic [31:0] int_value;
      logic [1:0]  func;
   } item_type;

   typedef struct packed {
      logic        overflow;
      logic [31:0] result_bits;
   } result_type;

endpackage

// ----- rtl/q24_8_fixed_float_converter.sv -----
// path from req beat to rsp beat: input register, then result register
// throughput: one beat per cycle; the result register stalls only when rsp_tready is low
// the conversion is one combinational pass between the two registers
// reset: synchronous, active high; clears both valid flags, payload is not reset
module q24_8_fixed_float_converter
   import qfc_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,   // func, int_value, float_bits, fixed_value, zero pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [39:0]  rsp_tdata    // result_bits, overflow, zero pad
);

   item_type   item_ff, item_in;
   logic       in_vld_ff, in_vld_in;
   result_type res_ff, res_in;
   logic       out_vld_ff, out_vld_in;
   logic       adv;
   logic [31:0] f2x, x2f, x2i;
   logic        f2x_ovf;

   assign adv        = !out_vld_ff || rsp_tready;
   assign req_tready = !in_vld_ff || adv;

   qfc_float_to_fixed #(.FRAC_BITS(FRAC_BITS)) u_f2x (
      .float_bits (item_ff.float_bits),
      .result_bits(f2x),
      .overflow   (f2x_ovf)
   );

   qfc_fixed_to_float #(.FRAC_BITS(FRAC_BITS)) u_x2f (
      .fixed_value(item_ff.fixed_value),
      .result_bits(x2f)
   );

   assign x2i = 32'($signed(item_ff.fixed_value) >>> FRAC_BITS);

   always_comb begin
      res_in = '0;
      unique case (func_type'(item_ff.func))
         FUNC_INT_TO_FIX: res_in.result_bits = item_ff.int_value << FRAC_BITS;
         FUNC_FLT_TO_FIX: begin
            res_in.result_bits = f2x;
            res_in.overflow    = f2x_ovf;
         end
         FUNC_FIX_TO_FLT: res_in.result_bits = x2f;
         default:         res_in.result_bits = x2i;
      endcase
   end

   always_comb begin
      item_in    = (req_tvalid && req_tready) ? item_type'(req_tdata[97:0]) : item_ff;
      in_vld_in  = req_tready ? req_tvalid : in_vld_ff;
      out_vld_in = adv ? in_vld_ff : out_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (adv && in_vld_ff) begin
         res_ff <= res_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {7'd0, res_ff};

`ifndef SYNTH
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under stall");
   a_ovf_func: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[32] |->
         (rsp_tdata[31:0] == 32'h7FFF_FFFF || rsp_tdata[31:0] == 32'h8000_0000))
      else $error("overflow flag without saturated value");
   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && out_vld_ff && !rsp_tready |-> !req_tready)
      else $error("accepted while full");
`endif

endmodule

// ----- rtl/qfc_float_to_fixed.sv -----
module qfc_float_to_fixed
   import qfc_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic [31:0] float_bits,
   output logic [31:0] result_bits,
   output logic        overflow
);

   logic        sign;
   logic [7:0]  expo;
   logic [22:0] frac;
   logic [23:0] mant;
   logic [9:0]  sh;
   logic [9:0]  n;
   logic [56:0] shl;
   logic [25:0] rnd;
   logic [32:0] mag;

   always_comb begin
      sign = float_bits[31];
      expo = float_bits[30:23];
      frac = float_bits[22:0];
      mant = (expo == 8'd0) ? {1'b0, frac} : {1'b1, frac};
      // biased exponent offset so that sh = e - 150 + frac_bits, subnormals use e = 1
      sh   = ((expo == 8'd0) ? 10'd1 : {2'b00, expo}) + 10'(FRAC_BITS) - 10'd150;
      n    = 10'd0 - sh;
      shl  = {33'd0, mant} << sh[4:0];
      rnd  = 26'd0;
      mag  = 33'd0;
      overflow    = 1'b0;
      result_bits = 32'd0;
      if (expo == 8'hFF) begin
         overflow    = 1'b1;
         result_bits = (frac != 23'd0 || !sign) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end else if (!sh[9] && sh > 10'd31) begin
         overflow    = 1'b1;
         result_bits = sign ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         if (!sh[9]) begin
            // any bit above 31 folds into bit 32 so the range checks still saturate
            mag = {(shl[56:32] != 25'd0), shl[31:0]};
         end else if (n > 10'd25) begin
            mag = 33'd0;
         end else begin
            rnd = ({2'b00, mant} + (26'd1 << (n[4:0] - 5'd1))) >> n[4:0];
            mag = {7'd0, rnd};
         end
         if (sign) begin
            if (mag > 33'h0_8000_0000) begin
               overflow    = 1'b1;
               result_bits = 32'h8000_0000;
            end else begin
               result_bits = 32'd0 - mag[31:0];
            end
         end else if (mag > 33'h0_7FFF_FFFF) begin
            overflow    = 1'b1;
            result_bits = 32'h7FFF_FFFF;
         end else begin
            result_bits = mag[31:0];
         end
      end
   end

endmodule

// ----- rtl/qfc_fixed_to_float.sv -----
module qfc_fixed_to_float
   import qfc_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic [31:0] fixed_value,
   output logic [31:0] result_bits
);

   logic        sign;
   logic [31:0] mag;
   logic [4:0]  p;
   logic [31:0] norm;
   logic [24:0] mant;
   logic        guard;
   logic        sticky;
   logic [7:0]  bexp;

   always_comb begin
      sign = fixed_value[31];
      mag  = sign ? (32'd0 - fixed_value) : fixed_value;
      p    = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (mag[i]) begin
            p = 5'(i);
         end
      end
      // msb moved to bit 31, then rounded to nearest even at 24 bits
      norm   = mag << (5'd31 - p);
      guard  = norm[7];
      sticky = norm[6:0] != 7'd0;
      mant   = {1'b0, norm[31:8]};
      if (guard && (sticky || norm[8])) begin
         mant = mant + 25'd1;
      end
      bexp = 8'(p) + 8'(127 - FRAC_BITS);
      if (mant[24]) begin
         bexp = bexp + 8'd1;
         mant = mant >> 1;
      end
      result_bits = (mag == 32'd0) ? 32'd0 : {sign, bexp, mant[22:0]};
   end

endmodule

// ----- tb/q24_8_fixed_float_converter_tb.sv -----
`timescale 1ns / 100ps

module q24_8_fixed_float_converter_tb;
   import qfc_pkg::*;

   localparam int LIMIT_CYCLES = 200000;
   localparam int FRAC = 8;

   typedef struct {
      logic [31:0] result_bits;
      logic        overflow;
   } conv_result_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [103:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [39:0]  rsp_tdata;

   conv_result_type expected_q[$];
   int  mismatches;
   int  cycle_count;
   bit  sink_idle_en;
   bit  src_idle_en;
   int  sink_hold;

   q24_8_fixed_float_converter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic conv_result_type flt_to_fix(logic [31:0] f);
      conv_result_type r;
      logic        sgn;
      int          ex;
      logic [63:0] mant;
      logic [63:0] mag;
      int          sh;
      sgn = f[31];
      ex = f[30:23];
      mant = {41'd0, f[22:0]};
      r.overflow = 1'b0;
      if (ex == 255) begin
         r.overflow = 1'b1;
         r.result_bits = (mant != 0 || !sgn) ? 32'h7FFF_FFFF : 32'h8000_0000;
         return r;
      end
      if (ex == 0) ex = 1;
      else mant[23] = 1'b1;
      sh = ex - 150 + FRAC;
      if (sh > 31) begin
         r.overflow = 1'b1;
         r.result_bits = sgn ? 32'h8000_0000 : 32'h7FFF_FFFF;
         return r;
      end
      if (sh >= 0) mag = mant << sh;
      else if (-sh > 25) mag = 0;
      else mag = (mant + (64'd1 << (-sh - 1))) >> (-sh);
      if (sgn) begin
         if (mag > 64'h8000_0000) begin
            r.overflow = 1'b1;
            r.result_bits = 32'h8000_0000;
         end else begin
            r.result_bits = 32'd0 - mag[31:0];
         end
      end else if (mag > 64'h7FFF_FFFF) begin
         r.overflow = 1'b1;
         r.result_bits = 32'h7FFF_FFFF;
      end else begin
         r.result_bits = mag[31:0];
      end
      return r;
   endfunction

   function automatic logic [31:0] fix_to_flt(logic [31:0] x);
      logic [31:0] mag;
      logic [31:0] mant;
      logic [31:0] rem;
      logic [31:0] half;
      int          msb;
      int          s;
      logic [7:0]  bexp;
      mag = x[31] ? 32'd0 - x : x;
      if (mag == 0) return 32'd0;
      msb = 0;
      for (int i = 0; i < 32; i++) if (mag[i]) msb = i;
      bexp = 8'(msb + 127 - FRAC);
      if (msb <= 23) begin
         mant = mag << (23 - msb);
      end else begin
         s = msb - 23;
         rem = mag & ((32'd1 << s) - 1);
         half = 32'd1 << (s - 1);
         mant = mag >> s;
         if (rem > half || (rem == half && mant[0])) mant = mant + 1;
         if (mant[24]) begin
            mant = mant >> 1;
            bexp = bexp + 1;
         end
      end
      return {x[31], bexp, mant[22:0]};
   endfunction

   function automatic conv_result_type convert(item_type it);
      conv_result_type r;
      r.overflow = 1'b0;
      case (func_type'(it.func))
         FUNC_INT_TO_FIX: r.result_bits = it.int_value << FRAC;
         FUNC_FLT_TO_FIX: r = flt_to_fix(it.float_bits);
         FUNC_FIX_TO_FLT: r.result_bits = fix_to_flt(it.fixed_value);
         default:         r.result_bits = $signed(it.fixed_value) >>> FRAC;
      endcase
      return r;
   endfunction

   // one beat per call; the valid stays high when the next beat follows at once
   task automatic send_item(func_type fn, logic [31:0] iv, logic [31:0] fb, logic [31:0] xv);
      item_type it;
      int gap;
      it.func = fn;
      it.int_value = iv;
      it.float_bits = fb;
      it.fixed_value = xv;
      if (src_idle_en && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 5);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, it};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_q.push_back(convert(it));
   endtask

   task automatic end_burst();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_float();
      logic [31:0] f;
      f = $urandom();
      case ($urandom_range(0, 5))
         0: f[30:23] = $urandom_range(118, 160);
         1: f[30:23] = $urandom_range(150, 158);
         2: f[30:23] = 8'hFF;
         3: f[30:23] = $urandom_range(0, 3);
         default: f[30:23] = $urandom_range(100, 170);
      endcase
      return f;
   endfunction

   task automatic test_int_to_fixed();
      send_item(FUNC_INT_TO_FIX, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(FUNC_INT_TO_FIX, 32'h7FFF_FFFF, 0, 0);
      send_item(FUNC_INT_TO_FIX, 32'h8000_0000, 0, 0);
      send_item(FUNC_INT_TO_FIX, 32'hFFFF_FFFF, 0, 0);
      send_item(FUNC_INT_TO_FIX, 32'h007F_FFFF, 0, 0);
      end_burst();
   endtask

   task automatic test_float_to_fixed();
      send_item(FUNC_FLT_TO_FIX, 0, 32'h7F80_0000, 0);   // +inf
      send_item(FUNC_FLT_TO_FIX, 0, 32'hFF80_0000, 0);   // -inf
      send_item(FUNC_FLT_TO_FIX, 0, 32'h7FC0_0001, 0);   // nan
      send_item(FUNC_FLT_TO_FIX, 0, 32'hFFFF_FFFF, 0);   // negative nan
      send_item(FUNC_FLT_TO_FIX, 0, 32'hCB00_0000, 0);   // exactly -2^31 fixed
      send_item(FUNC_FLT_TO_FIX, 0, 32'h4B00_0000, 0);   // just over max
      send_item(FUNC_FLT_TO_FIX, 0, 32'h8000_0000, 0);   // -0
      send_item(FUNC_FLT_TO_FIX, 0, 32'h0000_0001, 0);   // subnormal
      send_item(FUNC_FLT_TO_FIX, 0, 32'h3B00_0000, 0);   // half lsb rounds away
      send_item(FUNC_FLT_TO_FIX, 0, 32'hBB00_0000, 0);
      send_item(FUNC_FLT_TO_FIX, 0, 32'h3F80_0000, 0);
      send_item(FUNC_FLT_TO_FIX, 0, 32'h7F00_0000, 0);   // far above range
      send_item(FUNC_FLT_TO_FIX, 0, 32'hCF00_0000, 0);   // shift of 16
      end_burst();
   endtask

   task automatic test_fixed_conversions();
      logic [31:0] vals[6] = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                               32'h0100_0001, 32'h0000_0180};
      foreach (vals[i]) begin
         send_item(FUNC_FIX_TO_FLT, 0, 0, vals[i]);
         send_item(FUNC_FIX_TO_INT, 0, 0, vals[i]);
      end
      end_burst();
   endtask

   task automatic test_random(int count);
      logic [31:0] xv;
      for (int n = 0; n < count; n++) begin
         xv = $urandom();
         if ($urandom_range(0, 2) == 0) xv = $signed(xv) >>> $urandom_range(0, 31);
         send_item(func_type'($urandom_range(0, 3)), $urandom(), rand_float(), xv);
      end
      end_burst();
   endtask

   // the sink holds off long enough that the input side backs up
   task automatic test_backpressure();
      sink_idle_en = 1'b0;
      repeat (6) @(posedge clock);
      sink_hold = 40;
      sink_idle_en = 1'b1;
      test_random(30);
      wait_drained();
      repeat (20) @(posedge clock);
      test_random(20);
      wait_drained();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (sink_hold > 0) begin
         sink_hold <= sink_hold - 1;
         rsp_tready <= 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
         sink_hold <= $urandom_range(0, 4);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      conv_result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %h", rsp_tdata);
         end else begin
            exp_r = expected_q.pop_front();
            if (rsp_tdata[31:0] !== exp_r.result_bits || rsp_tdata[32] !== exp_r.overflow) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h ovf %b, got %h ovf %b",
                           exp_r.result_bits, exp_r.overflow, rsp_tdata[31:0], rsp_tdata[32]);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      mismatches = 0;
      cycle_count = 0;
      sink_hold = 0;
      sink_idle_en = 1'b0;
      src_idle_en = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_int_to_fixed();
      test_float_to_fixed();
      test_fixed_conversions();
      sink_idle_en = 1'b1;
      src_idle_en = 1'b1;
      test_random(500);
      test_backpressure();
      test_random(250);
      sink_idle_en = 1'b0;
      src_idle_en = 1'b0;
      test_random(120);
      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
